FILE: sv/ncs_pkg.sv
// Shared types, constants and the round function of the cube-sum block.
// Depends on nothing; imported by every module of the block but ncs_fifo.
package ncs_pkg;

    localparam int unsigned NCS_CUBE_WIDTH = 32;
    localparam int unsigned NCS_MAX_ROUNDS = 1023;
    localparam int unsigned NCS_QDEPTH     = 2;

    localparam logic [31:0] NCS_NLF_TABLE  = 32'h3a5c742e;

    localparam logic [63:0] NCS_KEY_RST    = 64'd0;
    localparam logic [9:0]  NCS_ROUNDS_RST = 10'd528;
    localparam logic [31:0] NCS_MASK_RST   = 32'd1;

    typedef enum logic [1:0] {
        CFG_KEY    = 2'd0,
        CFG_ROUNDS = 2'd1,
        CFG_MASK   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] plaintext;
        logic        last;
    } t_work;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_SCAN,
        FE_PUSH
    } t_fe_state;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_bk_state;

    // one step of the nonlinear feedback register
    function automatic logic [31:0] ncs_round(input logic [31:0] s, input logic key_bit);
        logic [4:0] sel;
        logic       fb;
        sel = {s[31], s[26], s[20], s[9], s[1]};
        fb  = NCS_NLF_TABLE[sel] ^ key_bit ^ s[16] ^ s[0];
        return {fb, s[31:1]};
    endfunction

endpackage

FILE: sv/ncs_fifo.sv
// Small register-based queue between the front and back parts.
// Depends on nothing; width and depth come from the instantiating module.
module ncs_fifo #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/ncs_front.sv
// Front part: accepts index beats and scatters index bits into the mask positions.
// Depends on ncs_pkg; feeds the work queue.
module ncs_front #(
    parameter int unsigned CUBE_WIDTH = ncs_pkg::NCS_CUBE_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [31:0]   i_cube_index,
    input  logic          i_last,
    input  logic [31:0]   i_cube_mask,
    input  logic          i_q_full,
    output logic          o_q_push,
    output ncs_pkg::t_work o_q_data
);
    import ncs_pkg::*;

    t_fe_state             r_state, n_state;
    logic [CUBE_WIDTH-1:0] r_idx;
    logic [31:0]           r_pt;
    logic [4:0]            r_pos;
    logic                  r_last;
    logic                  accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FE_IDLE: if (i_in_valid) n_state = FE_SCAN;
            FE_SCAN: if (r_pos == 5'd31) n_state = FE_PUSH;
            FE_PUSH: if (!i_q_full) n_state = FE_IDLE;
            default: n_state = FE_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready         = (r_state == FE_IDLE);
        accept             = o_in_ready && i_in_valid;
        o_q_push           = (r_state == FE_PUSH) && !i_q_full;
        o_q_data.plaintext = r_pt;
        o_q_data.last      = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // index bits beyond CUBE_WIDTH never enter r_idx
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= i_cube_index[CUBE_WIDTH-1:0];
            r_last <= i_last;
            r_pt   <= '0;
            r_pos  <= '0;
        end else if (r_state == FE_SCAN) begin
            if (i_cube_mask[r_pos]) begin
                r_pt[r_pos] <= r_idx[0];
                r_idx       <= r_idx >> 1;
            end
            r_pos <= r_pos + 1'b1;
        end
    end

endmodule

FILE: sv/ncs_back.sv
// Back part: runs the cipher one round per cycle, accumulates and emits sums.
// Depends on ncs_pkg; drains the work queue and drives the result register.
module ncs_back #(
    parameter int unsigned MAX_ROUNDS = ncs_pkg::NCS_MAX_ROUNDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [63:0]    i_cipher_key,
    input  logic [9:0]     i_round_count,
    input  logic           i_q_valid,
    input  ncs_pkg::t_work i_q_data,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [31:0]    o_cube_sum,
    output logic [5:0]     o_zero_bit_count
);
    import ncs_pkg::*;

    localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);
    localparam int unsigned CW = (RW > 10) ? RW : 10;
    localparam logic [CW-1:0] MAX_R = CW'(MAX_ROUNDS);

    t_bk_state   r_state, n_state;
    logic [31:0] r_s;
    logic [CW-1:0] r_rnd;
    logic        r_last;
    logic [31:0] r_acc;
    logic        r_out_valid;
    logic [31:0] r_sum;
    logic [5:0]  r_zcnt;

    logic [CW-1:0] lim;
    logic [31:0]   sum;
    logic          done, fin_ok, pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_q_valid) n_state = BK_RUN;
            BK_RUN:  if (fin_ok && !i_q_valid) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        lim    = (CW'(i_round_count) > MAX_R) ? MAX_R : CW'(i_round_count);
        done   = (r_state == BK_RUN) && (r_rnd == lim);
        fin_ok = done && (!r_last || !r_out_valid || i_out_ready);
        pop    = i_q_valid && ((r_state == BK_IDLE) || fin_ok);
        sum    = r_acc ^ r_s;
    end

    assign o_q_pop          = pop;
    assign o_out_valid      = r_out_valid;
    assign o_cube_sum       = r_sum;
    assign o_zero_bit_count = r_zcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_ok) begin
                r_acc <= r_last ? '0 : sum;
            end
            if (fin_ok && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s    <= i_q_data.plaintext;
            r_last <= i_q_data.last;
            r_rnd  <= '0;
        end else if (r_state == BK_RUN && !done) begin
            r_s   <= ncs_round(r_s, i_cipher_key[r_rnd[5:0]]);
            r_rnd <= r_rnd + 1'b1;
        end
        if (fin_ok && r_last) begin
            r_sum  <= sum;
            r_zcnt <= 6'($countones(~sum));
        end
    end

endmodule

FILE: sv/nlfsr_cipher_cube_sum.sv
// Cube-sum engine: each index beat is scattered into the masked plaintext
// positions by the front scanner, queued, and encrypted by a single shared
// round unit at one round per cycle, running min(round_count, MAX_ROUNDS)
// rounds per index (528 at reset), while the front scanner may take and scatter
// the next index beat. Ciphertexts
// are XOR-accumulated; a beat with last set yields one result beat carrying the
// sum and its zero-bit count, then the sum restarts at zero. A finished result
// waits in an output register while further index beats are taken.
// Depends on ncs_pkg, ncs_front, ncs_fifo and ncs_back.
module nlfsr_cipher_cube_sum #(
    parameter int unsigned CUBE_WIDTH = ncs_pkg::NCS_CUBE_WIDTH,
    parameter int unsigned MAX_ROUNDS = ncs_pkg::NCS_MAX_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_cube_index,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_cube_sum,
    output logic [5:0]  o_zero_bit_count
);
    import ncs_pkg::*;

    localparam int unsigned QW = $bits(t_work);

    logic [63:0] r_key;
    logic [9:0]  r_rounds;
    logic [31:0] r_mask;

    logic          q_push, q_full, q_pop, q_valid;
    t_work         q_wdata, q_rdata;
    logic [QW-1:0] q_rbits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= NCS_KEY_RST;
            r_rounds <= NCS_ROUNDS_RST;
            r_mask   <= NCS_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY:    r_key    <= i_cfg_data;
                CFG_ROUNDS: r_rounds <= i_cfg_data[9:0];
                CFG_MASK:   r_mask   <= i_cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    ncs_front #(
        .CUBE_WIDTH (CUBE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cube_index (i_cube_index),
        .i_last       (i_last),
        .i_cube_mask  (r_mask),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    ncs_fifo #(
        .WIDTH (QW),
        .DEPTH (NCS_QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rbits)
    );

    assign q_rdata = t_work'(q_rbits);

    ncs_back #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cipher_key     (r_key),
        .i_round_count    (r_rounds),
        .i_q_valid        (q_valid),
        .i_q_data         (q_rdata),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cube_sum       (o_cube_sum),
        .o_zero_bit_count (o_zero_bit_count)
    );

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32 - $countones(o_cube_sum)) == int'(o_zero_bit_count))
        else $error("zero-bit count does not match sum");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("work queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("work queue popped while empty");

endmodule

FILE: bench/cube_sum_checker.sv
// Cube-sum checker: watches config writes and both handshakes, predicts each
// sum from the scattered, encrypted indices and compares result beats in order.
// Depends on ncs_pkg for register codes, reset values and the feedback table.
module cube_sum_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_cube_index,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_cube_sum,
    input  logic [5:0]  i_zero_bit_count,
    output int          o_err_cnt,
    output int          o_pending,
    output int          o_sum_cnt
);
    import ncs_pkg::*;

    typedef struct packed {
        logic [31:0] total;
        logic [5:0]  zeros;
    } t_cube_result;

    t_cube_result sum_q[$];

    logic [63:0] key_r;
    logic [9:0]  rounds_r;
    logic [31:0] mask_r;
    logic [31:0] ct_xor;

    initial begin
        o_err_cnt = 0;
        o_pending = 0;
        o_sum_cnt = 0;
    end

    function automatic logic [31:0] spread_index(input logic [31:0] idx,
                                                 input logic [31:0] mask);
        logic [31:0] pt;
        int unsigned b;
        int unsigned pos;
        pt = '0;
        b  = 0;
        for (pos = 0; pos < 32; pos++) begin
            if (mask[pos]) begin
                if (b < NCS_CUBE_WIDTH) pt[pos] = idx[b];
                b++;
            end
        end
        return pt;
    endfunction

    function automatic logic [31:0] encrypt_block(input logic [63:0] key,
                                                  input logic [31:0] pt,
                                                  input logic [9:0]  rounds);
        logic [31:0] st;
        logic [4:0]  tap;
        logic        fb;
        int unsigned lim;
        int unsigned r;
        st  = pt;
        lim = (rounds > NCS_MAX_ROUNDS) ? NCS_MAX_ROUNDS : int'(rounds);
        for (r = 0; r < lim; r++) begin
            tap = {st[31], st[26], st[20], st[9], st[1]};
            fb  = NCS_NLF_TABLE[tap] ^ key[r % 64] ^ st[16] ^ st[0];
            st  = {fb, st[31:1]};
        end
        return st;
    endfunction

    function automatic logic [5:0] zero_bits(input logic [31:0] v);
        logic [5:0]  n;
        int unsigned i;
        n = '0;
        for (i = 0; i < 32; i++) begin
            if (!v[i]) n++;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result beat %0d: %s got %h want %h",
                 o_sum_cnt, what, got, want);
        o_err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_cube_result want;
        if (!i_rst_n) begin
            key_r    = NCS_KEY_RST;
            rounds_r = NCS_ROUNDS_RST;
            mask_r   = NCS_MASK_RST;
            ct_xor   = '0;
            sum_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY:    key_r    = i_cfg_data;
                    CFG_ROUNDS: rounds_r = i_cfg_data[9:0];
                    CFG_MASK:   mask_r   = i_cfg_data[31:0];
                    default:    ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (sum_q.size() == 0) begin
                    report_mismatch("beat with no sum pending, cube_sum", i_cube_sum, '0);
                end else begin
                    want = sum_q.pop_front();
                    if (i_cube_sum !== want.total) begin
                        report_mismatch("cube_sum", i_cube_sum, want.total);
                    end
                    if (i_zero_bit_count !== want.zeros) begin
                        report_mismatch("zero_bit_count", 32'(i_zero_bit_count),
                                        32'(want.zeros));
                    end
                end
                o_sum_cnt++;
            end
            if (i_in_valid && i_in_ready) begin
                ct_xor ^= encrypt_block(key_r, spread_index(i_cube_index, mask_r), rounds_r);
                if (i_last) begin
                    sum_q.push_back('{total: ct_xor, zeros: zero_bits(ct_xor)});
                    ct_xor = '0;
                end
            end
        end
        o_pending = sum_q.size();
    end

endmodule

FILE: bench/tb.sv
// Top of the cube-sum bench: clock, reset, register settings and index beats
// with random idling on both channels; verdict from the checker's counts.
// Depends on ncs_pkg, nlfsr_cipher_cube_sum and cube_sum_checker.
module tb;
    import ncs_pkg::*;

    localparam logic [1:0]  CFG_NONE    = 2'd3;
    localparam int unsigned BEAT_TARGET = 1130;
    localparam int unsigned QUIET_AFTER = 1000;
    localparam int unsigned CYCLE_LIMIT = 10000000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_idx    = CFG_KEY;
    logic [63:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic [31:0] i_cube_index = '0;
    logic        i_last       = 1'b0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_cube_sum;
    logic [5:0]  o_zero_bit_count;

    int          err_cnt;
    int          pend_cnt;
    int          sum_cnt;
    bit          idle_on    = 1'b1;
    int unsigned stall_left = 0;
    int unsigned beats_sent = 0;
    int unsigned phase_cnt  = 0;
    int unsigned cycle_cnt  = 0;
    logic [9:0]  cur_rounds = NCS_ROUNDS_RST;

    nlfsr_cipher_cube_sum u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cube_index     (i_cube_index),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cube_sum       (o_cube_sum),
        .o_zero_bit_count (o_zero_bit_count)
    );

    cube_sum_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cube_index     (i_cube_index),
        .i_last           (i_last),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_cube_sum       (o_cube_sum),
        .i_zero_bit_count (o_zero_bit_count),
        .o_err_cnt        (err_cnt),
        .o_pending        (pend_cnt),
        .o_sum_cnt        (sum_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[nlfsr_cipher_cube_sum] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // upper data bits are junk on purpose; only the register width counts
    task automatic set_phase(input logic [63:0] key, input logic [9:0] rounds,
                             input logic [31:0] mask, input bit stray);
        write_reg(CFG_KEY, key);
        write_reg(CFG_ROUNDS, {$urandom, 22'($urandom), rounds});
        write_reg(CFG_MASK, {$urandom, mask});
        if (stray) write_reg(CFG_NONE, {$urandom, $urandom});
        i_cfg_we   <= 1'b0;
        cur_rounds  = rounds;
        phase_cnt++;
    endtask

    task automatic send_beat(input logic [31:0] idx, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cube_index <= idx;
        i_last       <= lst;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pend_cnt != 0);
        repeat (int'(cur_rounds) + 80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] sparse_mask(input int unsigned k);
        logic [31:0] m;
        m = '0;
        while ($countones(m) < k) m[$urandom_range(0, 31)] = 1'b1;
        return m;
    endfunction

    initial begin
        logic [31:0] mask;
        logic [9:0]  rounds;
        int unsigned k;
        int unsigned n;
        int unsigned i;
        int unsigned reps;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-bit cube, surplus index bits
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1);
        drain();
        // zero rounds, full mask, then a write to an unused index
        set_phase('1, 10'd0, 32'hFFFF_FFFF, 1'b1);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1);
        send_beat(32'h5A5A_5A5A, 1'b1);
        drain();
        // empty mask
        set_phase('0, 10'd1, 32'h0000_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h1234_5678, 1'b1);
        drain();
        // max rounds over a two-bit cube at both end positions
        set_phase(64'h0123_4567_89AB_CDEF, 10'd1023, 32'h8000_0001, 1'b0);
        for (i = 0; i < 4; i++) send_beat(i, i == 3);
        drain();
        // key bit index covers all 64 key bits without wrapping
        set_phase({$urandom, $urandom}, 10'd64, 32'hF0F0_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1);
        send_beat(32'h0000_0000, 1'b1);
        send_beat(32'h8000_0000, 1'b1);
        drain();
        // same index twice cancels to an all-zero sum
        set_phase(64'h8000_0000_0000_0001, 10'd65, 32'h8000_0000, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'h0000_0001, 1'b1);
        drain();

        while (beats_sent < BEAT_TARGET) begin
            case ($urandom_range(0, 15))
                0:       rounds = 10'd1023;
                1:       rounds = 10'd528;
                2:       rounds = 10'd0;
                default: rounds = 10'($urandom_range(1, 64));
            endcase
            idle_on = beats_sent < QUIET_AFTER && $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 2) != 0) begin
                // full cubes, junk in the index bits past the cube
                k = (rounds > 64) ? 1 : $urandom_range(1, 5);
                mask = sparse_mask(k);
                set_phase({$urandom, $urandom}, rounds, mask, $urandom_range(0, 7) == 0);
                reps = $urandom_range(1, 3);
                repeat (reps) begin
                    for (i = 0; i < (32'd1 << k); i++) begin
                        send_beat(($urandom << k) | i, i == (32'd1 << k) - 1);
                    end
                end
            end else begin
                n = (rounds > 64) ? $urandom_range(2, 5) : $urandom_range(8, 40);
                case ($urandom_range(0, 3))
                    0:       mask = '1;
                    1:       mask = '0;
                    default: mask = $urandom;
                endcase
                set_phase({$urandom, $urandom}, rounds, mask, $urandom_range(0, 7) == 0);
                for (i = 0; i < n; i++) begin
                    send_beat($urandom, i == n - 1 || $urandom_range(0, 5) == 0);
                end
            end
            drain();
        end

        $display("%0d index beats over %0d register settings, %0d sums compared",
                 beats_sent, phase_cnt, sum_cnt);
        $display("rounds 0 to 1023, empty, sparse and full masks, %0d cycles", cycle_cnt);
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("[nlfsr_cipher_cube_sum] OK");
        end else begin
            $display("[nlfsr_cipher_cube_sum] ERROR");
        end
        $finish;
    end

endmodule
